// ----- rtl/mrx_pkg.sv -----
// ----------------------------------------------------------------------------
// mrx_pkg
// Shared constants for the mini RISC execute step: sizes, opcodes, functs.
// ----------------------------------------------------------------------------
package mrx_pkg;

  localparam int DATA_WORDS = 256;
  localparam int REG_COUNT  = 8;
  localparam int XLEN       = 32;
  localparam int DS_AW      = $clog2(DATA_WORDS);
  localparam int RF_AW      = $clog2(REG_COUNT);
  localparam int PC_W       = 8;
  localparam int PLEN_W     = 9;
  localparam int INSTR_W    = 16;

  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_JUMP  = 4'd2;
  localparam logic [3:0] OP_LOADI = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LOAD  = 4'd11;
  localparam logic [3:0] OP_STORE = 4'd15;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;

endpackage

// ----- rtl/mini_risc_execute_step.sv -----
// ----------------------------------------------------------------------------
// mini_risc_execute_step
// Registered path: RAM read and s1 capture, then execute result registers.
// Throughput: one request per cycle unless the result stalls; register file
// and data store RAM reads overlap the previous write-back via forwarding.
// Reset (rst, synchronous): clears pc, program length, pipeline valids and
// the per-entry valid bits of both RAMs, so every entry reads as zero.
// ----------------------------------------------------------------------------
module mini_risc_execute_step
  import mrx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [PLEN_W-1:0]        cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [INSTR_W-1:0]       instr_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PC_W-1:0]          next_pc,
  output logic                     reg_written,
  output logic [RF_AW-1:0]         reg_index,
  output logic signed [XLEN-1:0]   reg_value,
  output logic                     mem_written,
  output logic                     done_res
);

  logic [PLEN_W-1:0]     program_length;
  logic [PC_W-1:0]       prog_counter;
  logic [REG_COUNT-1:0]  rf_valid;
  logic [DATA_WORDS-1:0] ds_valid;

  logic                  s1_valid;
  logic [INSTR_W-1:0]    s1_instr;
  logic                  rs_fwd;
  logic                  rt_fwd;
  logic                  rs_ok;
  logic                  rt_ok;
  logic [XLEN-1:0]       rf_fwd_val;
  logic                  ld_fwd;
  logic                  ld_ok;
  logic [XLEN-1:0]       ds_fwd_val;

  logic                  accept;
  logic                  s1_fire;

  logic [RF_AW-1:0]      in_rs;
  logic [RF_AW-1:0]      in_rt;
  logic [DS_AW-1:0]      in_daddr;

  logic [XLEN-1:0]       rf_a_q;
  logic [XLEN-1:0]       rf_b_q;
  logic [XLEN-1:0]       ds_q;

  logic [XLEN-1:0]       op_a;
  logic [XLEN-1:0]       op_b;
  logic [XLEN-1:0]       ld_val;

  logic [3:0]            opcode;
  logic [RF_AW-1:0]      s1_rt;
  logic [RF_AW-1:0]      s1_rd;
  logic [2:0]            funct;
  logic [5:0]            imm;
  logic [6:0]            addr;
  logic [DS_AW-1:0]      s1_daddr;

  logic                  rf_we;
  logic [RF_AW-1:0]      rf_widx;
  logic [XLEN-1:0]       rf_wval;
  logic                  ds_we;
  logic [PLEN_W-1:0]     target;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign accept   = in_valid && in_ready;

  assign in_rs    = instr_word[11:9];
  assign in_rt    = instr_word[8:6];
  assign in_daddr = DS_AW'(instr_word[5:0]);

  mrx_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_widx),
    .wdata (rf_wval),
    .re    (accept),
    .raddr (in_rs),
    .rdata (rf_a_q)
  );

  mrx_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_widx),
    .wdata (rf_wval),
    .re    (accept),
    .raddr (in_rt),
    .rdata (rf_b_q)
  );

  mrx_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_ds (
    .clk   (clk),
    .we    (ds_we),
    .waddr (s1_daddr),
    .wdata (op_b),
    .re    (accept),
    .raddr (in_daddr),
    .rdata (ds_q)
  );

  assign opcode   = s1_instr[15:12];
  assign s1_rt    = s1_instr[8:6];
  assign s1_rd    = s1_instr[5:3];
  assign funct    = s1_instr[2:0];
  assign imm      = s1_instr[5:0];
  assign addr     = s1_instr[6:0];
  assign s1_daddr = DS_AW'(imm);

  assign op_a   = rs_fwd ? rf_fwd_val : (rs_ok ? rf_a_q : '0);
  assign op_b   = rt_fwd ? rf_fwd_val : (rt_ok ? rf_b_q : '0);
  assign ld_val = ld_fwd ? ds_fwd_val : (ld_ok ? ds_q : '0);

  always_comb begin
    logic wrote;
    logic stored;
    wrote   = 1'b0;
    stored  = 1'b0;
    rf_widx = '0;
    rf_wval = '0;
    target  = PLEN_W'(prog_counter) + PLEN_W'(1);
    case (opcode)
      OP_RTYPE: begin
        case (funct)
          FN_ADD: begin
            wrote   = 1'b1;
            rf_widx = s1_rd;
            rf_wval = op_a + op_b;
          end
          FN_SUB: begin
            wrote   = 1'b1;
            rf_widx = s1_rd;
            rf_wval = op_a - op_b;
          end
          default: ;
        endcase
      end
      OP_LOADI: begin
        wrote   = 1'b1;
        rf_widx = s1_rt;
        rf_wval = XLEN'(imm);
      end
      OP_LOAD: begin
        wrote   = 1'b1;
        rf_widx = s1_rt;
        rf_wval = ld_val;
      end
      OP_STORE: begin
        stored = 1'b1;
      end
      OP_BEQ: begin
        if (op_a == op_b) begin
          target = target + PLEN_W'(imm);
        end
      end
      OP_JUMP: begin
        target = target + PLEN_W'(addr);
      end
      default: ;
    endcase
    rf_we = s1_fire && wrote;
    ds_we = s1_fire && stored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
      prog_counter   <= '0;
      rf_valid       <= '0;
      ds_valid       <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        program_length <= cfg_wr_data;
      end
      if (rf_we) begin
        rf_valid[rf_widx] <= 1'b1;
      end
      if (ds_we) begin
        ds_valid[s1_daddr] <= 1'b1;
      end
      if (s1_fire) begin
        prog_counter <= target[PC_W-1:0];
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // capture same-cycle write-back for the request entering execute
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr   <= instr_word;
      rs_fwd     <= rf_we && (rf_widx == in_rs);
      rt_fwd     <= rf_we && (rf_widx == in_rt);
      rs_ok      <= rf_valid[in_rs];
      rt_ok      <= rf_valid[in_rt];
      rf_fwd_val <= rf_wval;
      ld_fwd     <= ds_we && (s1_daddr == in_daddr);
      ld_ok      <= ds_valid[in_daddr];
      ds_fwd_val <= op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      next_pc     <= target[PC_W-1:0];
      reg_written <= rf_we;
      reg_index   <= rf_widx;
      reg_value   <= rf_wval;
      mem_written <= ds_we;
      done_res    <= (target >= program_length);
    end
  end

endmodule

// ----- rtl/mrx_ram.sv -----
// ----------------------------------------------------------------------------
// mrx_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mrx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mrx_checker.sv -----
// ----------------------------------------------------------------------------
// mrx_checker
// Port-level checks on the execute step's result channel.
// ----------------------------------------------------------------------------
module mrx_checker
  import mrx_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [PC_W-1:0]        next_pc,
  input logic                   reg_written,
  input logic [RF_AW-1:0]       reg_index,
  input logic signed [XLEN-1:0] reg_value,
  input logic                   mem_written,
  input logic                   done_res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(reg_value)
      && $stable(reg_index) && $stable(reg_written) && $stable(mem_written)
      && $stable(done_res))
    else $error("result changed while stalled");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_written |-> reg_index == '0 && reg_value == '0)
    else $error("index or value set without a register write");

  a_one_effect: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(reg_written && mem_written))
    else $error("register write and store in one result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind mini_risc_execute_step mrx_checker u_mrx_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .next_pc     (next_pc),
  .reg_written (reg_written),
  .reg_index   (reg_index),
  .reg_value   (reg_value),
  .mem_written (mem_written),
  .done_res    (done_res)
);
